>>> src/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg: shared definitions for the wildcard byte pattern scanner
// Sizes, register codes and the structs that link the scanner's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

  // Window depth in bytes (longest usable pattern), range 1 to 16.
  localparam int MAX_PATTERN_BYTES = 16;
  // Width of the region position counter, range 8 to 64.
  localparam int OFFSET_BITS = 32;

  // Field widths fixed by the interface.
  localparam int BYTE_W    = 8;
  localparam int OFFSET_W  = 32;
  localparam int WORD_W    = 64;
  localparam int CARE_W    = 16;
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_STOP_FIRST   = 3'd4
  } wbps_reg_t;

  // Current register contents as seen by the scan logic.
  typedef struct packed {
    logic [WORD_W-1:0] pattern_low;
    logic [WORD_W-1:0] pattern_high;
    logic [CARE_W-1:0] care_mask;
    logic [LEN_W-1:0]  pattern_length;
    logic              stop_after_first;
  } wbps_cfg_t;

  // Outcome of scanning one accepted byte.
  typedef struct packed {
    logic                hit;
    logic [OFFSET_W-1:0] offset;
  } wbps_result_t;

endpackage

`default_nettype wire

>>> src/wbps_cfg.sv
// ----------------------------------------------------------------------------
// wbps_cfg: configuration register file
// Holds the pattern, care mask, length and stop mode written over the cfg port.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wbps_pkg::WORD_W-1:0]    cfg_data,
  output wbps_pkg::wbps_cfg_t                 cfg
);

  wbps_pkg::wbps_cfg_t cfg_r;
  wbps_pkg::wbps_cfg_t cfg_nxt;
  logic                wr_en;

  // Writes are always taken.
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;

  // Decode the register index; unknown indexes leave everything as it is.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_index)
        wbps_pkg::REG_PATTERN_LOW: begin
          cfg_nxt.pattern_low = cfg_data;
        end
        wbps_pkg::REG_PATTERN_HIGH: begin
          cfg_nxt.pattern_high = cfg_data;
        end
        wbps_pkg::REG_CARE_MASK: begin
          cfg_nxt.care_mask = cfg_data[wbps_pkg::CARE_W-1:0];
        end
        wbps_pkg::REG_PATTERN_LEN: begin
          cfg_nxt.pattern_length = cfg_data[wbps_pkg::LEN_W-1:0];
        end
        wbps_pkg::REG_STOP_FIRST: begin
          cfg_nxt.stop_after_first = cfg_data[0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> src/wbps_window.sv
// ----------------------------------------------------------------------------
// wbps_window: byte window, region position and pattern compare
// Shifts each accepted byte into the window and compares the newest bytes
// against the pattern in parallel, giving a hit and its start offset.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_window (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic [wbps_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                        last_in_region,
  input  wire wbps_pkg::wbps_cfg_t         cfg,
  output wbps_pkg::wbps_result_t           result
);

  localparam int MAXB  = wbps_pkg::MAX_PATTERN_BYTES;
  localparam int IDX_W = (MAXB > 1) ? $clog2(MAXB) : 1;
  localparam int OFFW  = wbps_pkg::OFFSET_BITS;
  localparam int OUTW  = wbps_pkg::OFFSET_W;
  localparam int LENW  = wbps_pkg::LEN_W;
  localparam int BW    = wbps_pkg::BYTE_W;

  logic [BW-1:0]         win_r     [MAXB];
  logic [BW-1:0]         win_nxt   [MAXB];
  logic [BW-1:0]         win_shift [MAXB];
  logic [OFFW-1:0]       seen_r;
  logic [OFFW-1:0]       seen_nxt;
  logic                  stopped_r;
  logic                  stopped_nxt;
  logic [OFFW-1:0]       taken;
  logic [OFFW-1:0]       start_pos;
  logic [OFFW+OUTW-1:0]  start_ext;
  logic [2*wbps_pkg::WORD_W-1:0] pattern;
  logic [LENW-1:0]       len;
  logic                  len_ok;
  logic                  fits;
  logic                  saturated;
  logic                  bytes_match;
  logic                  hit;

  assign pattern = {cfg.pattern_high, cfg.pattern_low};
  assign len     = cfg.pattern_length;

  // Window as it stands once the new byte is in: entry 0 is the newest.
  always_comb begin
    win_shift[0] = data_byte;
    for (int k = 1; k < MAXB; k++) begin
      win_shift[k] = win_r[k-1];
    end
  end

  // Pattern byte j lines up with the byte seen len-1-j steps ago.
  always_comb begin
    logic [LENW-1:0] idx;
    bytes_match = 1'b1;
    for (int j = 0; j < MAXB; j++) begin
      idx = len - LENW'(j) - LENW'(1);
      if ((LENW'(j) < len) && cfg.care_mask[j]) begin
        if (win_shift[idx[IDX_W-1:0]] != pattern[BW*j +: BW]) begin
          bytes_match = 1'b0;
        end
      end
    end
  end

  // Qualify the compare by length, region progress, saturation and stop mode.
  assign saturated = &seen_r;
  assign taken     = seen_r + OFFW'(1);
  assign len_ok    = (len != '0) && (len <= LENW'(MAXB));
  assign fits      = taken >= OFFW'(len);
  assign hit       = accept && !saturated && len_ok && fits && !stopped_r && bytes_match;

  // Start offset, cut or zero-extended to the output width.
  assign start_pos = taken - OFFW'(len);
  assign start_ext = {{OUTW{1'b0}}, start_pos};

  assign result.hit    = hit;
  assign result.offset = start_ext[OUTW-1:0];

  // Next state: the end of a region clears window, position and stop flag.
  always_comb begin
    for (int k = 0; k < MAXB; k++) begin
      win_nxt[k] = win_r[k];
    end
    seen_nxt    = seen_r;
    stopped_nxt = stopped_r;
    if (accept) begin
      if (last_in_region) begin
        for (int k = 0; k < MAXB; k++) begin
          win_nxt[k] = '0;
        end
        seen_nxt    = '0;
        stopped_nxt = 1'b0;
      end else begin
        for (int k = 0; k < MAXB; k++) begin
          win_nxt[k] = win_shift[k];
        end
        seen_nxt    = saturated ? seen_r : taken;
        stopped_nxt = stopped_r || (hit && cfg.stop_after_first);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAXB; k++) begin
        win_r[k] <= '0;
      end
      seen_r    <= '0;
      stopped_r <= 1'b0;
    end else begin
      for (int k = 0; k < MAXB; k++) begin
        win_r[k] <= win_nxt[k];
      end
      seen_r    <= seen_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // A region end leaves position and stop flag cleared.
  a_region_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_in_region) |=> (seen_r == '0) && !stopped_r)
    else $error("region end did not clear scan state");

  // No hit is ever reported while matches are suppressed.
  a_stopped_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> !result.hit)
    else $error("hit reported while stopped");

  // A hit in stop mode inside a region suppresses the next byte's hit.
  a_stop_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (hit && cfg.stop_after_first && !last_in_region) |=> stopped_r)
    else $error("stop flag not set after first match");

endmodule

`default_nettype wire

>>> src/wbps_out.sv
// ----------------------------------------------------------------------------
// wbps_out: two-entry output buffer
// A result register plus a skid register, so input beats keep flowing after
// the receiver stalls, until a further hit fills the skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_out (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire wbps_pkg::wbps_result_t        result,
  output logic                               in_ready,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [wbps_pkg::OFFSET_W-1:0]      out_tdata
);

  logic                          main_valid_r;
  logic                          main_valid_nxt;
  logic [wbps_pkg::OFFSET_W-1:0] main_data_r;
  logic [wbps_pkg::OFFSET_W-1:0] main_data_nxt;
  logic                          skid_valid_r;
  logic                          skid_valid_nxt;
  logic [wbps_pkg::OFFSET_W-1:0] skid_data_r;
  logic [wbps_pkg::OFFSET_W-1:0] skid_data_nxt;
  logic                          push;
  logic                          pop;

  // Input beats are taken while the skid register is free.
  assign in_ready = !skid_valid_r;
  assign push     = result.hit;
  assign pop      = main_valid_r && out_tready;

  // Refill the result register from the skid register first, then from a new hit.
  always_comb begin
    main_valid_nxt = main_valid_r;
    main_data_nxt  = main_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_valid_nxt = 1'b1;
        main_data_nxt  = result.offset;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = result.offset;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = main_valid_r;
  assign out_tdata  = main_data_r;

  // The skid register only fills behind a full result register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry without result entry");

  // A hit that finds the result register stalled lands in the skid register.
  a_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && main_valid_r && !pop) |=> skid_valid_r && main_valid_r)
    else $error("stalled hit not held in skid register");

  // Draining with the skid full moves the skid entry up.
  a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> main_valid_r && !skid_valid_r
      && (main_data_r == $past(skid_data_r)))
    else $error("skid entry not moved to result register");

endmodule

`default_nettype wire

>>> src/wildcard_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan: streaming wildcard byte pattern search
// Scans a memory region byte by byte and reports where masked patterns start.
// ----------------------------------------------------------------------------
// Usage:
//   Load the pattern, care mask, length and stop mode over the cfg channel
//   while no bytes are in flight. Then stream the region on the in_ channel,
//   one byte per beat, with in_tlast on the final byte of each region.
//   Every beat that completes a match produces one out_ beat carrying the
//   region offset of the first matched byte; other beats produce nothing.
// Result path and input rate:
//   A hit accepted at a clock edge goes at that edge into the result register
//   if it is free or draining, else into the skid register. One byte is taken
//   every cycle while in_tready is high; the window compare is combinational.
// Reset:
//   rst_n clears the control and window registers to zero, empties the window and the output
//   buffer, and restarts the region position.
// Stalls:
//   The output holds two results (result plus skid register). While both are
//   full, in_tready is low until the receiver takes a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scan (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input bytes. tdata: data_byte[7:0]. tlast: last_in_region.
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [wbps_pkg::BYTE_W-1:0]    in_tdata,
  input  wire logic                           in_tlast,
  // Match results. tdata: match_offset[31:0].
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [wbps_pkg::OFFSET_W-1:0]       out_tdata,
  // Register writes.
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wbps_pkg::WORD_W-1:0]    cfg_data
);

  wbps_pkg::wbps_cfg_t    cfg;
  wbps_pkg::wbps_result_t result;
  logic                   in_fire;

  assign in_fire = in_tvalid && in_tready;

  // Configuration registers.
  wbps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Window, position and compare.
  wbps_window u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_fire),
    .data_byte      (in_tdata),
    .last_in_region (in_tlast),
    .cfg            (cfg),
    .result         (result)
  );

  // Output buffer.
  wbps_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .result     (result),
    .in_ready   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for wildcard_byte_pattern_scan
// Streams byte regions through the scanner while a software copy of the
// window, position counter and stop flag predicts every match offset. Each
// result beat is compared with the oldest predicted offset. Register settings
// change between phases, and both sides of the stream stall at random.
// ----------------------------------------------------------------------------

// Tracks the scanner state and the match offsets still owed by the block.
class scan_predictor;
  bit [wbps_pkg::WORD_W-1:0]      pat_lo;
  bit [wbps_pkg::WORD_W-1:0]      pat_hi;
  bit [wbps_pkg::CARE_W-1:0]      care;
  bit [wbps_pkg::LEN_W-1:0]       len;
  bit                             stop_first;
  bit [wbps_pkg::BYTE_W-1:0]      win [wbps_pkg::MAX_PATTERN_BYTES];
  bit [wbps_pkg::OFFSET_BITS-1:0] seen;
  bit                             stopped;
  bit [wbps_pkg::OFFSET_W-1:0]    offsets_due [$];
  int                             errors;
  int                             hits_checked;

  // Register writes; indexes outside the map are dropped.
  function void write_reg(bit [wbps_pkg::CFG_IDX_W-1:0] idx, bit [63:0] val);
    case (idx)
      wbps_pkg::REG_PATTERN_LOW:  pat_lo = val;
      wbps_pkg::REG_PATTERN_HIGH: pat_hi = val;
      wbps_pkg::REG_CARE_MASK:    care = val[wbps_pkg::CARE_W-1:0];
      wbps_pkg::REG_PATTERN_LEN:  len = val[wbps_pkg::LEN_W-1:0];
      wbps_pkg::REG_STOP_FIRST:   stop_first = val[0];
      default: ;
    endcase
  endfunction

  function bit [7:0] pattern_byte(int j);
    bit [127:0] both;
    both = {pat_hi, pat_lo};
    return both[j*8 +: 8];
  endfunction

  // The oldest of the last len bytes in the window lines up with pattern byte 0.
  function bit window_hit();
    for (int j = 0; j < len; j++) begin
      if (care[j] && win[len-1-j] != pattern_byte(j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Called for every accepted input beat.
  function void take_byte(bit [7:0] b, bit last_flag);
    for (int k = wbps_pkg::MAX_PATTERN_BYTES - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = b;
    // A saturated position shifts the byte in but reports nothing.
    if (seen != '1) begin
      seen++;
      if (len != 0 && len <= wbps_pkg::MAX_PATTERN_BYTES && seen >= len &&
          !stopped && window_hit()) begin
        offsets_due.insert(offsets_due.size(), wbps_pkg::OFFSET_W'(seen - len));
        if (stop_first) stopped = 1'b1;
      end
    end
    // The region end clears the window, the position and the stop flag.
    if (last_flag) begin
      foreach (win[k]) win[k] = '0;
      seen = '0;
      stopped = 1'b0;
    end
  endfunction

  // Called for every accepted result beat.
  function void check_offset(logic [wbps_pkg::OFFSET_W-1:0] actual);
    bit [wbps_pkg::OFFSET_W-1:0] want;
    if (offsets_due.size() == 0) begin
      $display("%0t: match_offset mismatch, expected no beat, actual %0d", $time, actual);
      errors++;
    end else begin
      want = offsets_due.pop_front();
      hits_checked++;
      if (actual !== want) begin
        $display("%0t: match_offset mismatch, expected %0d, actual %0d",
                 $time, want, actual);
        errors++;
      end
    end
  endfunction
endclass

module testbench;
  import wbps_pkg::*;

  localparam int GAP_MAX      = 6;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 4;
  localparam int IDLE_LIMIT   = 1000;
  localparam int TARGET_BYTES = 1750;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OFFSET_W-1:0]  out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  scan_predictor scan = new();

  bit tx_steady;
  bit rx_steady;
  bit rx_hold_req;
  int holds_done;
  int bytes_sent;
  int regions_sent;
  int settings_used;
  int idle_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wildcard_byte_pattern_scan uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // One register write; cfg_valid stays high so writes can follow back to back.
  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    scan.write_reg(idx, val);
  endtask

  // Writes the whole register set, sometimes with a stray write to an unused index.
  task automatic program_scan(bit [63:0] lo, bit [63:0] hi, bit [63:0] care_word,
                              bit [63:0] len_word, bit [63:0] stop_word);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_CARE_MASK, care_word);
    write_reg(REG_PATTERN_LEN, len_word);
    write_reg(REG_STOP_FIRST, stop_word);
    if ($urandom_range(0, 3) == 0) write_reg(3'($urandom_range(5, 7)), {$urandom, $urandom});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Offers one byte after a random gap and waits for the beat to be taken.
  task automatic send_byte(bit [7:0] b, bit last_flag);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last_flag;
    do @(posedge clk); while (!in_tready);
    scan.take_byte(b, last_flag);
    bytes_sent++;
    if (last_flag) regions_sent++;
  endtask

  // Waits until every predicted offset has arrived and the pipeline has settled.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (scan.offsets_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Builds a region from planted pattern copies, pattern bytes and noise.
  task automatic send_region(int n, bit close);
    bit [7:0] region_bytes [$];
    int plen;
    plen = scan.len;
    while (region_bytes.size() < n) begin
      if (plen >= 1 && plen <= MAX_PATTERN_BYTES && $urandom_range(0, 2) == 0) begin
        for (int j = 0; j < plen; j++)
          region_bytes.insert(region_bytes.size(),
                              scan.care[j] ? scan.pattern_byte(j) : 8'($urandom));
      end else if (plen >= 1 && $urandom_range(0, 1) == 0) begin
        region_bytes.insert(region_bytes.size(),
                            scan.pattern_byte($urandom_range(0, MAX_PATTERN_BYTES - 1)));
      end else begin
        region_bytes.insert(region_bytes.size(), 8'($urandom));
      end
    end
    for (int j = 0; j < n; j++) send_byte(region_bytes[j], close && j == n - 1);
  endtask

  // One random setting followed by a few regions, sometimes leaving one open.
  task automatic random_phase();
    bit [63:0] lo;
    bit [63:0] hi;
    bit [63:0] care_word;
    bit [63:0] len_word;
    int n;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: begin lo = '0; hi = '0; end
      1: begin lo = '1; hi = '1; end
      default: ;
    endcase
    care_word = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: care_word[CARE_W-1:0] = '0;
      1: care_word[CARE_W-1:0] = '1;
      default: ;
    endcase
    // Junk above the length field must be ignored by the block.
    len_word = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: len_word[LEN_W-1:0] = 0;
      1: len_word[LEN_W-1:0] = MAX_PATTERN_BYTES;
      2: len_word[LEN_W-1:0] = $urandom_range(MAX_PATTERN_BYTES + 1, 31);
      3: len_word[LEN_W-1:0] = 1;
      default: len_word[LEN_W-1:0] = $urandom_range(1, MAX_PATTERN_BYTES);
    endcase
    program_scan(lo, hi, care_word, len_word, {$urandom, $urandom});
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(2, 5)) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(1, 3);
        1: n = $urandom_range(40, 80);
        default: n = $urandom_range(5, 30);
      endcase
      send_region(n, 1'b1);
    end
    // An open region carries over into the next setting.
    if ($urandom_range(0, 2) == 0) send_region($urandom_range(1, 8), 1'b0);
    drain();
  endtask

  // Receiver: random stalls per beat, plus one long hold-off on request.
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
        holds_done++;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, GAP_MAX);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
        do @(posedge clk); while (!out_tvalid);
      end
    end
  end

  // Every result beat is checked against the oldest predicted offset.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) scan.check_offset(out_tdata);
  end

  // Watchdog: too long without any beat on any channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles, stopping", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at reset give a zero length, so nothing may match.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    // Pattern AA ?? FF with care bits set beyond the length.
    write_reg(3'($urandom_range(5, 7)), {$urandom, $urandom});
    program_scan(64'h0000_0000_00FF_00AA, '1, 64'hFFFD, 64'd3, 64'd0);
    send_byte(8'hAA, 1'b0); send_byte(8'h37, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b1);
    drain();

    // Stop after the first match; the region end re-arms it.
    write_reg(REG_STOP_FIRST, 64'd1);
    cfg_valid <= 1'b0;
    send_byte(8'hAA, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0); send_byte(8'h02, 1'b0); send_byte(8'hFF, 1'b1);
    send_byte(8'hAA, 1'b0); send_byte(8'h03, 1'b0); send_byte(8'hFF, 1'b0);
    drain();

    // Clearing the mode mid-region leaves the stop in force.
    write_reg(REG_STOP_FIRST, 64'd0);
    cfg_valid <= 1'b0;
    send_byte(8'hAA, 1'b0); send_byte(8'h04, 1'b0); send_byte(8'hFF, 1'b1);
    // A region shorter than the pattern.
    send_byte(8'hAA, 1'b0); send_byte(8'hFF, 1'b1);
    drain();

    // All wildcards: every position matches.
    program_scan('1, '1, 64'd0, 64'd1, 64'd0);
    send_byte(8'h5A, 1'b0); send_byte(8'hA5, 1'b1);
    drain();

    // Random settings and regions, with one flood against a held-off receiver.
    while (bytes_sent < TARGET_BYTES) begin
      random_phase();
      if (holds_done == 0 && bytes_sent > 600) begin
        program_scan('0, '0, 64'd0, 64'd1, 64'd0);
        tx_steady = 1'b1;
        rx_hold_req = 1'b1;
        send_region(40, 1'b1);
        drain();
      end
    end
    drain();

    $display("Scanned %0d bytes in %0d closed regions under %0d register settings.",
             bytes_sent, regions_sent, settings_used);
    $display("Checked %0d match offsets; receiver backed up the input %0d time(s).",
             scan.hits_checked, holds_done);
    if (scan.errors == 0 && scan.offsets_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
